>>> sv/klb_pkg.sv
`timescale 1ns / 1ps

package klb_pkg;

    localparam int LINE_CAPACITY_DEF = 19;

    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd10;
    localparam logic [15:0] IDLE_COUNT_MAX     = 16'hffff;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_IDLE_TIMEOUT = 1'b0
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_ECHO       = 2'd0,
        KIND_BACKSPACE  = 2'd1,
        KIND_LINE_CHAR  = 2'd2,
        KIND_EMPTY_LINE = 2'd3
    } kind_t;

    localparam logic [7:0] KEY_BACKSPACE = 8'h2a;
    localparam logic [7:0] KEY_SUBMIT    = 8'h23;
    localparam logic [7:0] CHAR_NONE     = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } key_info_t;

    function automatic logic [7:0] key_layout(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] code;
        unique case ({row, col})
            4'h0: code = 8'h31;
            4'h1: code = 8'h32;
            4'h2: code = 8'h33;
            4'h3: code = 8'h41;
            4'h4: code = 8'h34;
            4'h5: code = 8'h35;
            4'h6: code = 8'h36;
            4'h7: code = 8'h42;
            4'h8: code = 8'h37;
            4'h9: code = 8'h38;
            4'ha: code = 8'h39;
            4'hb: code = 8'h43;
            4'hc: code = 8'h2a;
            4'hd: code = 8'h30;
            4'he: code = 8'h23;
            4'hf: code = 8'h44;
            default: code = 8'h44;
        endcase
        return code;
    endfunction

endpackage

>>> sv/klb_ram.sv
`timescale 1ns / 1ps

module klb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 19,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/klb_keydec.sv
`timescale 1ns / 1ps

module klb_keydec (
    input  logic [3:0]         row_lines,
    input  logic [3:0]         col_lines,
    output klb_pkg::key_info_t key
);

    logic       row_ok;
    logic       col_ok;
    logic [1:0] row_idx;
    logic [1:0] col_idx;

    // bit 3 is the first line, exactly one low line required
    always_comb begin
        row_ok  = 1'b1;
        row_idx = 2'd0;
        unique case (~row_lines)
            4'b1000: row_idx = 2'd0;
            4'b0100: row_idx = 2'd1;
            4'b0010: row_idx = 2'd2;
            4'b0001: row_idx = 2'd3;
            default: row_ok  = 1'b0;
        endcase
    end

    always_comb begin
        col_ok  = 1'b1;
        col_idx = 2'd0;
        unique case (~col_lines)
            4'b1000: col_idx = 2'd0;
            4'b0100: col_idx = 2'd1;
            4'b0010: col_idx = 2'd2;
            4'b0001: col_idx = 2'd3;
            default: col_ok  = 1'b0;
        endcase
    end

    assign key.hit  = row_ok && col_ok;
    assign key.code = klb_pkg::key_layout(row_idx, col_idx);

endmodule

>>> sv/keypad_line_entry_buffer.sv
`timescale 1ns / 1ps

// Line entry from a 4x4 matrix keypad (layout 123A / 456B / 789C / *0#D). Each
// input transaction is a scan sample (s_cmd 0) or an idle tick (s_cmd 1). A scan
// with exactly one low row and one low column is a key: '*' deletes the last
// character, '#' streams the stored line out as line characters with m_last on
// the final one (or one empty-line result) and clears it, any other key is
// echoed and appended, clearing a full line first. Ticks count idle time and
// discard the line once the count exceeds idle_timeout_ticks (register 0,
// byte address 0, reset 10). Items are handled one at a time. A submit reads
// the line through the single read port of the line RAM, one character per
// cycle while m_ready does not hold the output register. The next transaction is
// taken while an earlier result still waits in the output register.
module keypad_line_entry_buffer #(
    parameter int LINE_CAPACITY = klb_pkg::LINE_CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [klb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [klb_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [klb_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [3:0]                      s_row_lines,
    input  logic [3:0]                      s_col_lines,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_kind,
    output logic [7:0]                      m_char_code,
    output logic                            m_last
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);

    klb_pkg::state_t state_reg, state_next;

    logic [15:0]   timeout_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   idle_reg, idle_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;

    logic       cmd_reg;
    logic [3:0] row_reg;
    logic [3:0] col_reg;

    logic       m_valid_reg;
    logic [1:0] m_kind_reg, m_kind_next;
    logic [7:0] m_char_code_reg, m_char_code_next;
    logic       m_last_reg, m_last_next;
    logic       load_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    klb_pkg::key_info_t key;

    logic          s_fire;
    logic          out_free;
    logic          is_bs, is_sub, is_char;
    logic          fill_zero;
    logic          needs_out;
    logic          exec_wait;
    logic          start_stream;
    logic          send_last;
    logic [15:0]   idle_inc;
    logic [AW-1:0] app_addr;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == klb_pkg::REG_IDLE_TIMEOUT)
                  ? {{(klb_pkg::CFG_DATA_W - 16){1'b0}}, timeout_reg}
                  : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= klb_pkg::IDLE_TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == klb_pkg::REG_IDLE_TIMEOUT) begin
            timeout_reg <= pwdata[15:0];
        end
    end

    klb_keydec u_keydec (
        .row_lines (row_reg),
        .col_lines (col_reg),
        .key       (key)
    );

    klb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == klb_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign fill_zero    = (fill_reg == '0);
    assign is_bs        = key.hit && (key.code == klb_pkg::KEY_BACKSPACE);
    assign is_sub       = key.hit && (key.code == klb_pkg::KEY_SUBMIT);
    assign is_char      = key.hit && !is_bs && !is_sub;
    assign needs_out    = !cmd_reg && (is_char || (is_bs && !fill_zero) || (is_sub && fill_zero));
    assign exec_wait    = needs_out && !out_free;
    assign start_stream = !cmd_reg && is_sub && !fill_zero;
    assign send_last    = ((CW'(rd_idx_reg) + CW'(1)) == fill_reg);
    assign idle_inc     = (idle_reg == klb_pkg::IDLE_COUNT_MAX) ? idle_reg : idle_reg + 16'd1;
    assign app_addr     = (fill_reg >= CAP) ? '0 : AW'(fill_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            klb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = klb_pkg::ST_EXEC;
                end
            end
            klb_pkg::ST_EXEC: begin
                priority if (start_stream) begin
                    state_next = klb_pkg::ST_SEND;
                end else if (exec_wait) begin
                    state_next = klb_pkg::ST_EXEC;
                end else begin
                    state_next = klb_pkg::ST_IDLE;
                end
            end
            klb_pkg::ST_SEND: begin
                if (out_free && send_last) begin
                    state_next = klb_pkg::ST_IDLE;
                end
            end
            default: state_next = klb_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        fill_next        = fill_reg;
        idle_next        = idle_reg;
        rd_idx_next      = rd_idx_reg;
        load_out         = 1'b0;
        m_kind_next      = m_kind_reg;
        m_char_code_next = m_char_code_reg;
        m_last_next      = m_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = app_addr;
        ram_wdata        = key.code;
        ram_re           = 1'b0;
        ram_raddr        = '0;
        unique case (state_reg)
            klb_pkg::ST_IDLE: begin
            end
            klb_pkg::ST_EXEC: begin
                priority if (cmd_reg) begin
                    idle_next = idle_inc;
                    if (idle_inc > timeout_reg) begin
                        fill_next = '0;
                    end
                end else if (start_stream) begin
                    idle_next   = '0;
                    ram_re      = 1'b1;
                    ram_raddr   = '0;
                    rd_idx_next = '0;
                end else if (!key.hit) begin
                end else if (is_bs && fill_zero) begin
                    idle_next = '0;
                end else if (out_free) begin
                    idle_next   = '0;
                    load_out    = 1'b1;
                    m_last_next = 1'b1;
                    priority if (is_bs) begin
                        fill_next        = fill_reg - CW'(1);
                        m_kind_next      = klb_pkg::KIND_BACKSPACE;
                        m_char_code_next = klb_pkg::CHAR_NONE;
                    end else if (is_sub) begin
                        m_kind_next      = klb_pkg::KIND_EMPTY_LINE;
                        m_char_code_next = klb_pkg::CHAR_NONE;
                    end else begin
                        ram_we           = 1'b1;
                        fill_next        = CW'(app_addr) + CW'(1);
                        m_kind_next      = klb_pkg::KIND_ECHO;
                        m_char_code_next = key.code;
                    end
                end
            end
            klb_pkg::ST_SEND: begin
                if (out_free) begin
                    load_out         = 1'b1;
                    m_kind_next      = klb_pkg::KIND_LINE_CHAR;
                    m_char_code_next = ram_rdata;
                    m_last_next      = send_last;
                    if (send_last) begin
                        fill_next = '0;
                    end else begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        ram_re      = 1'b1;
                        ram_raddr   = rd_idx_reg + AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= klb_pkg::ST_IDLE;
            fill_reg    <= '0;
            idle_reg    <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            rd_idx_reg <= rd_idx_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and result registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_cmd;
            row_reg <= s_row_lines;
            col_reg <= s_col_lines;
        end
        if (load_out) begin
            m_kind_reg      <= m_kind_next;
            m_char_code_reg <= m_char_code_next;
            m_last_reg      <= m_last_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last      = m_last_reg;

endmodule
